/* hw/rtl/bsap_pkg.sv */
// Shared types and constants for the BLE sensor advertisement parser.
// Transfer payload structs, op codes, register indexes and AD field constants.
// No dependencies.
package bsap_pkg;

  typedef enum logic {
    OP_ADV_BYTE = 1'b0,
    OP_QUERY    = 1'b1
  } bsap_op_e;

  typedef enum logic [1:0] {
    REG_TARGET_ADDRESS = 2'd0,
    REG_ADDRESS_ENABLE = 2'd1,
    REG_STALE_MS       = 2'd2
  } bsap_reg_e;

  localparam int unsigned AddrWidth  = 48;
  localparam int unsigned TimeWidth  = 64;
  localparam int unsigned StaleWidth = 32;
  localparam int unsigned CfgWidth   = 48;

  localparam logic [StaleWidth-1:0] StaleMsReset = 32'd300000;

  localparam logic [7:0] AdTypeService = 8'h16;
  localparam logic [7:0] UuidLow       = 8'h3D;
  localparam logic [7:0] UuidHigh      = 8'hFD;
  localparam logic [7:0] UuidHdr       = 8'd3;
  localparam logic [7:0] MinFieldLen   = 8'd9;  // UUID header plus six payload bytes

  typedef struct packed {
    bsap_op_e               op;
    logic                   first_byte;
    logic                   last_byte;
    logic [7:0]             data_byte;
    logic [AddrWidth-1:0]   sender_address;
    logic [TimeWidth-1:0]   time_ms;
  } bsap_in_t;

  typedef struct packed {
    logic                   reading_valid;
    logic signed [11:0]     temperature_tenths;
    logic [6:0]             humidity;
    logic [TimeWidth-1:0]   last_seen_ms;
  } bsap_out_t;

  typedef struct packed {
    logic                   valid;
    logic signed [11:0]     temperature;
    logic [6:0]             humidity;
    logic [TimeWidth-1:0]   last_seen;
  } bsap_reading_t;

endpackage

/* hw/rtl/ble_sensor_advert_parser.sv */
// BLE sensor advertisement parser, top level.
// Path: a query waits in the input register, then is loaded into the result register once the slot is free.
// Throughput: one item per cycle while no query waits for the result slot; set by the walk state update.
// Stalls: a byte waits only in the input register; a query also waits for the result slot.
// Reset: walk state and stored reading cleared, registers to their reset values.
// Instantiates bsap_walker and bsap_result; depends on bsap_pkg.
module ble_sensor_advert_parser (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [1:0]                            cfg_index_i,
  input  logic [bsap_pkg::CfgWidth-1:0]         cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  bsap_pkg::bsap_in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output bsap_pkg::bsap_out_t                   out_data_o
);
  import bsap_pkg::*;

  logic [AddrWidth-1:0]  target_address_q;
  logic                  address_enable_q;
  logic [StaleWidth-1:0] stale_ms_q;

  logic                  in_valid_q, in_valid_d;
  bsap_in_t              in_q;
  logic                  advance;
  logic                  slot_free;
  logic                  in_xfer;
  bsap_reading_t         reading;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_address_q <= '0;
      address_enable_q <= 1'b0;
      stale_ms_q       <= StaleMsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TARGET_ADDRESS: target_address_q <= cfg_data_i[AddrWidth-1:0];
        REG_ADDRESS_ENABLE: address_enable_q <= cfg_data_i[0];
        REG_STALE_MS:       stale_ms_q       <= cfg_data_i[StaleWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  assign advance    = in_valid_q && (in_q.op == OP_ADV_BYTE || slot_free);
  assign in_ready_o = !in_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
  end

  bsap_walker u_walker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_en_i        (advance && in_q.op == OP_ADV_BYTE),
    .item_i           (in_q),
    .target_address_i (target_address_q),
    .address_enable_i (address_enable_q),
    .reading_o        (reading)
  );

  bsap_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && in_q.op == OP_QUERY),
    .now_i       (in_q.time_ms),
    .reading_i   (reading),
    .stale_ms_i  (stale_ms_q),
    .slot_free_o (slot_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_q && in_q.op == OP_QUERY))
    else $error("result without a query");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("held item lost while stalled");

endmodule

/* hw/rtl/bsap_walker.sv */
// Length-type field walker and stored sensor reading.
// Consumes one advertisement byte per step; depends on bsap_pkg.
module bsap_walker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  step_en_i,
  input  bsap_pkg::bsap_in_t                    item_i,
  input  logic [bsap_pkg::AddrWidth-1:0]        target_address_i,
  input  logic                                  address_enable_i,
  output bsap_pkg::bsap_reading_t               reading_o
);
  import bsap_pkg::*;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_TYPE,
    PH_BODY,
    PH_DONE
  } phase_e;

  localparam logic [7:0] PosUuidLow  = 8'd2;
  localparam logic [7:0] PosUuidHigh = 8'd3;
  localparam logic [7:0] PosTenths   = 8'd7;
  localparam logic [7:0] PosInteger  = 8'd8;
  localparam logic [7:0] PosHumidity = 8'd9;

  phase_e               phase_q, phase_d;
  logic [7:0]           left_q, left_d;
  logic [7:0]           len_q, len_d;
  logic                 cand_q, cand_d;
  logic [7:0]           pos_q, pos_d;
  logic [7:0]           tenths_q, tenths_d;
  logic [7:0]           integer_q, integer_d;
  logic [7:0]           humid_q, humid_d;
  logic                 accepted_q, accepted_d;
  logic [TimeWidth-1:0] ts_q, ts_d;
  bsap_reading_t        reading_q, reading_d;

  function automatic logic signed [11:0] to_tenths(input logic [7:0] int_b,
                                                   input logic [7:0] tenths_b);
    logic [10:0] mag;
    mag = {4'd0, int_b[6:0]} * 11'd10 + {7'd0, tenths_b[3:0]};
    if (int_b[7] || mag == 11'd0) begin
      return $signed({1'b0, mag});
    end
    return $signed(12'd0 - {1'b0, mag});
  endfunction

  always_comb begin
    phase_d    = phase_q;
    left_d     = left_q;
    len_d      = len_q;
    cand_d     = cand_q;
    pos_d      = pos_q;
    tenths_d   = tenths_q;
    integer_d  = integer_q;
    humid_d    = humid_q;
    accepted_d = accepted_q;
    ts_d       = ts_q;
    reading_d  = reading_q;
    if (step_en_i) begin
      if (item_i.first_byte) begin
        accepted_d = address_enable_i && (item_i.sender_address == target_address_i);
        ts_d       = item_i.time_ms;
        phase_d    = PH_LEN;
        left_d     = 8'd0;
        len_d      = 8'd0;
        cand_d     = 1'b0;
        pos_d      = 8'd0;
      end
      if (accepted_d) begin
        unique case (phase_d)
          PH_LEN: begin
            if (item_i.data_byte == 8'd0) begin
              phase_d = PH_DONE;
            end else begin
              len_d   = item_i.data_byte;
              left_d  = item_i.data_byte;
              phase_d = PH_TYPE;
            end
          end
          PH_TYPE: begin
            cand_d  = (item_i.data_byte == AdTypeService) && (len_d >= UuidHdr);
            pos_d   = PosUuidLow;
            left_d  = left_d - 8'd1;
            phase_d = PH_BODY;
          end
          PH_BODY: begin
            if (pos_d == PosUuidLow && item_i.data_byte != UuidLow) cand_d = 1'b0;
            if (pos_d == PosUuidHigh && item_i.data_byte != UuidHigh) cand_d = 1'b0;
            if (pos_d == PosTenths) tenths_d = item_i.data_byte;
            if (pos_d == PosInteger) integer_d = item_i.data_byte;
            if (pos_d == PosHumidity) humid_d = item_i.data_byte;
            pos_d  = pos_d + 8'd1;
            left_d = left_d - 8'd1;
          end
          PH_DONE: begin
          end
        endcase
        // field end: decide on candidate, else walk on to the next length byte
        if ((phase_q == PH_TYPE || phase_q == PH_BODY || item_i.first_byte == 1'b0)
            && phase_d == PH_BODY && left_d == 8'd0) begin
          if (cand_d) begin
            if (len_d >= MinFieldLen) begin
              reading_d.valid       = 1'b1;
              reading_d.temperature = to_tenths(integer_d, tenths_d);
              reading_d.humidity    = humid_d[6:0];
              reading_d.last_seen   = ts_d;
            end
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_LEN;
          end
        end
      end
      if (item_i.last_byte) begin
        accepted_d = 1'b0;
        phase_d    = PH_LEN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_LEN;
      left_q     <= '0;
      len_q      <= '0;
      cand_q     <= 1'b0;
      pos_q      <= '0;
      tenths_q   <= '0;
      integer_q  <= '0;
      humid_q    <= '0;
      accepted_q <= 1'b0;
      ts_q       <= '0;
      reading_q  <= '0;
    end else begin
      phase_q    <= phase_d;
      left_q     <= left_d;
      len_q      <= len_d;
      cand_q     <= cand_d;
      pos_q      <= pos_d;
      tenths_q   <= tenths_d;
      integer_q  <= integer_d;
      humid_q    <= humid_d;
      accepted_q <= accepted_d;
      ts_q       <= ts_d;
      reading_q  <= reading_d;
    end
  end

  assign reading_o = reading_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reading_q.valid |=> reading_q.valid)
    else $error("stored reading lost its valid flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accepted_q |-> phase_q == PH_LEN)
    else $error("walk active outside an accepted advert");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_en_i |=> $stable(reading_q) && $stable(phase_q))
    else $error("walk state changed without a byte");

endmodule

/* hw/rtl/bsap_result.sv */
// Query result stage: freshness check and output register.
// Depends on bsap_pkg.
module bsap_result (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  logic [bsap_pkg::TimeWidth-1:0]        now_i,
  input  bsap_pkg::bsap_reading_t               reading_i,
  input  logic [bsap_pkg::StaleWidth-1:0]       stale_ms_i,
  output logic                                  slot_free_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output bsap_pkg::bsap_out_t                   out_data_o
);
  import bsap_pkg::*;

  logic                 out_valid_q, out_valid_d;
  bsap_out_t            out_q;
  logic [TimeWidth-1:0] age;
  logic                 fresh;

  assign age   = now_i - reading_i.last_seen;
  assign fresh = reading_i.valid
              && (age < {{(TimeWidth-StaleWidth){1'b0}}, stale_ms_i});

  assign slot_free_o = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_i) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      out_q.reading_valid      <= fresh;
      out_q.temperature_tenths <= reading_i.temperature;
      out_q.humidity           <= reading_i.humidity;
      out_q.last_seen_ms       <= reading_i.last_seen;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> slot_free_o)
    else $error("result loaded over an untaken transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i && !load_i |=> out_valid_q && $stable(out_q))
    else $error("pending result dropped or changed");

endmodule

/* tb/bsap_reading_checker.sv */
`timescale 1ns / 100ps
// Checker for the BLE sensor advertisement parser: watches the config port and both
// channels, predicts every query result and compares it field by field.
// Depends on bsap_pkg.
module bsap_reading_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [bsap_pkg::CfgWidth-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  bsap_pkg::bsap_in_t            in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  bsap_pkg::bsap_out_t           out_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  import bsap_pkg::*;

  typedef enum logic [1:0] {
    WALK_LEN,
    WALK_TYPE,
    WALK_BODY,
    WALK_DONE
  } walk_phase_e;

  logic [AddrWidth-1:0]  cfg_target;
  logic                  cfg_enable;
  logic [StaleWidth-1:0] cfg_stale;

  walk_phase_e           phase;
  logic [7:0]            bytes_left;
  logic [7:0]            field_len;
  logic [7:0]            body_pos;
  logic [7:0]            tenths_b;
  logic [7:0]            whole_b;
  logic [7:0]            hum_b;
  logic                  candidate;
  logic                  accepting;
  logic [TimeWidth-1:0]  advert_time;
  bsap_reading_t         held;

  bsap_out_t             reading_q[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  task automatic close_field();
    int mag;
    if (candidate) begin
      if (field_len >= MinFieldLen) begin
        mag = int'(whole_b[6:0]) * 10 + int'(tenths_b[3:0]);
        held.temperature = (whole_b[7] || mag == 0) ? 12'(mag) : 12'(-mag);
        held.humidity    = hum_b[6:0];
        held.last_seen   = advert_time;
        held.valid       = 1'b1;
      end
      phase = WALK_DONE;
    end else begin
      phase = WALK_LEN;
    end
  endtask

  // query: snapshot of the held reading; byte: walk the length-type chain
  task automatic advance_reading(input bsap_in_t item);
    bsap_out_t  res;
    logic [7:0] b;
    b = item.data_byte;
    if (item.op == OP_QUERY) begin
      res.reading_valid      = held.valid &&
                               ((item.time_ms - held.last_seen) < TimeWidth'(cfg_stale));
      res.temperature_tenths = held.temperature;
      res.humidity           = held.humidity;
      res.last_seen_ms       = held.last_seen;
      reading_q.push_back(res);
    end else begin
      if (item.first_byte) begin
        accepting   = cfg_enable && (item.sender_address == cfg_target);
        advert_time = item.time_ms;
        phase       = WALK_LEN;
        bytes_left  = '0;
        field_len   = '0;
        candidate   = 1'b0;
        body_pos    = '0;
      end
      if (accepting) begin
        case (phase)
          WALK_LEN: begin
            if (b == 8'd0) begin
              phase = WALK_DONE;
            end else begin
              field_len  = b;
              bytes_left = b;
              phase      = WALK_TYPE;
            end
          end
          WALK_TYPE: begin
            candidate  = (b == AdTypeService) && (field_len >= UuidHdr);
            body_pos   = 8'd2;
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0) close_field();
            else phase = WALK_BODY;
          end
          WALK_BODY: begin
            if (body_pos == 8'd2 && b != UuidLow) candidate = 1'b0;
            if (body_pos == 8'd3 && b != UuidHigh) candidate = 1'b0;
            if (body_pos == 8'd7) tenths_b = b;
            if (body_pos == 8'd8) whole_b = b;
            if (body_pos == 8'd9) hum_b = b;
            body_pos   = body_pos + 8'd1;
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0) close_field();
          end
          default: ;
        endcase
      end
      if (item.last_byte) begin
        accepting = 1'b0;
        phase     = WALK_LEN;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bsap_out_t want;
    if (!rst_ni) begin
      cfg_target  = '0;
      cfg_enable  = 1'b0;
      cfg_stale   = StaleMsReset;
      phase       = WALK_LEN;
      bytes_left  = '0;
      field_len   = '0;
      body_pos    = '0;
      tenths_b    = '0;
      whole_b     = '0;
      hum_b       = '0;
      candidate   = 1'b0;
      accepting   = 1'b0;
      advert_time = '0;
      held        = '0;
      reading_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_TARGET_ADDRESS: cfg_target = cfg_data_i[AddrWidth-1:0];
          REG_ADDRESS_ENABLE: cfg_enable = cfg_data_i[0];
          REG_STALE_MS:       cfg_stale  = cfg_data_i[StaleWidth-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (reading_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("%0t: result transfer with nothing expected, got %0h", $time, out_data_i);
          end
        end else begin
          want = reading_q.pop_front();
          if (want.reading_valid !== out_data_i.reading_valid)
            report("reading_valid", 64'(want.reading_valid), 64'(out_data_i.reading_valid));
          if (want.temperature_tenths !== out_data_i.temperature_tenths)
            report("temperature_tenths", 64'(unsigned'(want.temperature_tenths)),
                   64'(unsigned'(out_data_i.temperature_tenths)));
          if (want.humidity !== out_data_i.humidity)
            report("humidity", 64'(want.humidity), 64'(out_data_i.humidity));
          if (want.last_seen_ms !== out_data_i.last_seen_ms)
            report("last_seen_ms", want.last_seen_ms, out_data_i.last_seen_ms);
        end
      end
      if (in_valid_i && in_ready_i) advance_reading(in_data_i);
    end
    pending_o = reading_q.size();
  end

endmodule

/* tb/tb_ble_sensor_advert_parser.sv */
`timescale 1ns / 100ps
// Testbench top for ble_sensor_advert_parser: drives adverts, queries and register
// settings, and gives the verdict from bsap_reading_checker.
// Depends on bsap_pkg, bsap_reading_checker and the parser RTL.
module tb_ble_sensor_advert_parser;
  import bsap_pkg::*;

  typedef logic [7:0] octet_q_t[$];

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = '0;
  logic [CfgWidth-1:0]   cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  bsap_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  bsap_out_t             out_data;

  int unsigned           fail_count;
  int unsigned           pending;
  int unsigned           items_sent = 0;
  bit                    idling_on = 1'b1;
  bit                    hold_off_req = 1'b0;
  bit                    hold_done = 1'b0;
  logic [AddrWidth-1:0]  target_cur = '0;
  logic [StaleWidth-1:0] stale_cur = StaleMsReset;
  logic [TimeWidth-1:0]  clock_ms = '0;

  ble_sensor_advert_parser u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  bsap_reading_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [TimeWidth-1:0] query_time();
    case ($urandom_range(0, 7))
      0:       return clock_ms + TimeWidth'(stale_cur) - 64'd1;
      1:       return clock_ms + TimeWidth'(stale_cur);
      2:       return clock_ms + TimeWidth'(stale_cur) + 64'd1;
      3:       return rand64();
      4:       return clock_ms - 64'($urandom_range(1, 100));
      default: return clock_ms + 64'($urandom_range(0, 2000));
    endcase
  endfunction

  function automatic logic [AddrWidth-1:0] pick_sender();
    case ($urandom_range(0, 7))
      0:       return target_cur ^ (48'd1 << $urandom_range(0, AddrWidth - 1));
      1:       return AddrWidth'(rand64());
      default: return target_cur;
    endcase
  endfunction

  task automatic push_item(input bsap_in_t item);
    if (idling_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_query(input logic [TimeWidth-1:0] now);
    bsap_in_t item;
    item.op             = OP_QUERY;
    item.first_byte     = 1'($urandom);
    item.last_byte      = 1'($urandom);
    item.data_byte      = 8'($urandom);
    item.sender_address = AddrWidth'(rand64());
    item.time_ms        = now;
    push_item(item);
  endtask

  // sender and stamp travel on the first byte; later bytes carry junk there
  task automatic send_octets(input octet_q_t octets, input logic [AddrWidth-1:0] sender,
                             input logic [TimeWidth-1:0] stamp, input bit close);
    bsap_in_t item;
    foreach (octets[i]) begin
      if (i != 0 && $urandom_range(0, 19) == 0) send_query(query_time());
      item.op             = OP_ADV_BYTE;
      item.first_byte     = (i == 0);
      item.last_byte      = close && (i == octets.size() - 1);
      item.data_byte      = octets[i];
      item.sender_address = (i == 0) ? sender : AddrWidth'(rand64());
      item.time_ms        = (i == 0) ? stamp : rand64();
      push_item(item);
    end
  endtask

  task automatic add_sensor_field(ref octet_q_t octets, input int flen,
                                  input logic [7:0] tenths, input logic [7:0] whole,
                                  input logic [7:0] hum);
    int pos;
    octets.push_back(8'(flen));
    octets.push_back(AdTypeService);
    for (pos = 2; pos <= flen; pos++) begin
      case (pos)
        2:       octets.push_back(UuidLow);
        3:       octets.push_back(UuidHigh);
        7:       octets.push_back(tenths);
        8:       octets.push_back(whole);
        9:       octets.push_back(hum);
        default: octets.push_back(8'($urandom));
      endcase
    end
  endtask

  task automatic random_advert(input logic [AddrWidth-1:0] sender,
                               input logic [TimeWidth-1:0] stamp);
    octet_q_t   octets;
    int         kind;
    int         flen;
    int         base;
    int         cut;
    logic [7:0] tenths;
    logic [7:0] whole;
    tenths = 8'($urandom);
    whole  = 8'($urandom);
    case ($urandom_range(0, 11))
      0: begin tenths[3:0] = 4'h0; whole = 8'h00; end
      1: begin tenths[3:0] = 4'h0; whole = 8'h80; end
      2: begin tenths[3:0] = 4'hF; whole = 8'hFF; end
      3: begin tenths[3:0] = 4'hF; whole = 8'h7F; end
      default: ;
    endcase
    kind = $urandom_range(0, 15);
    if (kind == 15) begin
      repeat ($urandom_range(1, 12)) octets.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 2)) begin
        flen = $urandom_range(1, 6);
        octets.push_back(8'(flen));
        repeat (flen) octets.push_back(8'($urandom));
      end
      flen = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(9, 12);
      base = octets.size();
      case (kind)
        11: begin
          octets.push_back(8'h00);
          add_sensor_field(octets, flen, tenths, whole, 8'($urandom));
        end
        12: add_sensor_field(octets, $urandom_range(3, 8), tenths, whole, 8'($urandom));
        13: begin
          // service type too short to carry a UUID, then a good field
          octets.push_back(8'($urandom_range(1, 2)));
          octets.push_back(AdTypeService);
          if (octets[base] == 8'd2) octets.push_back(UuidLow);
          add_sensor_field(octets, flen, tenths, whole, 8'($urandom));
        end
        14: begin
          add_sensor_field(octets, flen, tenths, whole, 8'($urandom));
          octets[base + $urandom_range(2, 3)] ^= 8'($urandom_range(1, 255));
        end
        default: add_sensor_field(octets, flen, tenths, whole, 8'($urandom));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        flen = $urandom_range(1, 5);
        octets.push_back(8'(flen));
        repeat (flen) octets.push_back(8'($urandom));
      end
    end
    if (octets.size() > 1 && $urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, octets.size() - 1);
      while (octets.size() > cut) void'(octets.pop_back());
    end
    send_octets(octets, sender, stamp, $urandom_range(0, 11) != 0);
    if ($urandom_range(0, 11) == 0) begin
      octets.delete();
      repeat ($urandom_range(1, 3)) octets.push_back(8'($urandom));
      send_octets(octets, sender, stamp, 1'b1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [AddrWidth-1:0] target, input logic enable,
                              input logic [StaleWidth-1:0] stale);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TARGET_ADDRESS;
    cfg_data  <= target;
    @(posedge clk);
    cfg_index <= REG_ADDRESS_ENABLE;
    cfg_data  <= {47'(rand64()), enable};
    @(posedge clk);
    cfg_index <= REG_STALE_MS;
    cfg_data  <= {16'($urandom), stale};
    @(posedge clk);
    cfg_we    <= 1'b0;
    target_cur = target;
    stale_cur  = stale;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_off_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_done = 1'b1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    octet_q_t    octets;
    bsap_in_t    item;
    int unsigned budget;
    logic        enable;
    budget = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: filter disabled, reading never set
    send_query(64'd0);
    item            = '0;
    item.op         = OP_ADV_BYTE;
    item.data_byte  = 8'h02;
    push_item(item);
    add_sensor_field(octets, 9, 8'h05, 8'h99, 8'h30);
    send_octets(octets, 48'h0, 64'd10, 1'b1);
    send_query(64'd20);
    wait_drained();
    program_regs(AddrWidth'(rand64()), 1'b1, 32'd1000);

    octets.delete();
    add_sensor_field(octets, 9, 8'hF5, 8'h19, 8'hB7);
    send_octets(octets, target_cur, 64'd5000, 1'b1);
    clock_ms = 64'd5000;
    send_query(64'd5999);
    send_query(64'd6000);
    octets.delete();
    octets.push_back(8'h00);
    octets.push_back(8'h09);
    send_octets(octets, target_cur, 64'd7000, 1'b1);
    send_query(64'hFFFF_FFFF_FFFF_FFFF);

    for (int ph = 1; ph <= 6; ph++) begin
      wait_drained();
      enable = 1'b1;
      case (ph)
        1: begin
          program_regs(AddrWidth'(rand64()), enable, 32'd1000);
          budget = items_sent + 350;
        end
        2: begin
          program_regs(48'hFFFF_FFFF_FFFF, enable, 32'd0);
          budget = items_sent + 250;
        end
        3: begin
          idling_on = 1'b0;
          program_regs(48'h0, enable, 32'hFFFF_FFFF);
          budget = items_sent + 250;
        end
        4: begin
          idling_on = 1'b1;
          enable    = 1'b0;
          program_regs(AddrWidth'(rand64()), enable, $urandom());
          budget = items_sent + 150;
        end
        5: begin
          program_regs(AddrWidth'(rand64()), enable, $urandom_range(1, 5000));
          budget = items_sent + 400;
        end
        default: begin
          idling_on = 1'b0;
          program_regs(AddrWidth'(rand64()), enable, StaleMsReset);
          budget = items_sent + 300;
        end
      endcase
      if (ph == 1) begin
        hold_off_req = 1'b1;
        repeat (60) send_query(query_time());
      end
      while (items_sent < budget) begin
        if ($urandom_range(0, 1) == 0) begin
          send_query(query_time());
        end else begin
          clock_ms = ($urandom_range(0, 63) == 0) ? rand64()
                                                   : clock_ms + 64'($urandom_range(0, 3000));
          random_advert(pick_sender(), clock_ms);
        end
      end
    end

    wait_drained();
    repeat (6) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
